@@ hdl/rtccal_pkg.sv @@
`default_nettype none
package rtccal_pkg;

	localparam int CMD_W     = 2;
	localparam int HOURS_W   = 5;
	localparam int MINUTES_W = 6;
	localparam int SECONDS_W = 6;
	localparam int NDAY_W    = 5;
	localparam int NMONTH_W  = 4;
	localparam int NYEAR_W   = 7;
	localparam int NWDAY_W   = 3;
	localparam int DAY_W     = 7;
	localparam int MONTH_W   = 7;
	localparam int YEAR_W    = 14;
	localparam int WDAY_W    = 7;
	localparam int LIMIT_W   = 6;

	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_TIME = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET_ALL  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

	localparam logic [DAY_W-1:0] ERR_MARK = 7'd99;

	localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd1990;
	localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
	localparam logic [YEAR_W-1:0] CENTURY    = 14'd100;

	localparam logic [SECONDS_W:0] SEC_LIMIT  = 7'd60;
	localparam logic [MINUTES_W:0] MIN_LIMIT  = 7'd60;
	localparam logic [HOURS_W:0]   HOUR_LIMIT = 6'd24;
	localparam logic [WDAY_W:0]    WDAY_LIMIT = 8'd7;
	localparam logic [MONTH_W:0]   MONTH_END  = 8'd13;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [HOURS_W-1:0]   new_hours;
		logic [MINUTES_W-1:0] new_minutes;
		logic [SECONDS_W-1:0] new_seconds;
		logic [NDAY_W-1:0]    new_day;
		logic [NMONTH_W-1:0]  new_month;
		logic [NYEAR_W-1:0]   new_year_high;
		logic [NYEAR_W-1:0]   new_year_low;
		logic [NWDAY_W-1:0]   new_weekday;
	} cmd_item_t;

	typedef struct packed {
		logic [HOURS_W-1:0]   hours;
		logic [MINUTES_W-1:0] minutes;
		logic [SECONDS_W-1:0] seconds;
		logic [DAY_W-1:0]     day;
		logic [MONTH_W-1:0]   month;
		logic [YEAR_W-1:0]    year;
		logic [WDAY_W-1:0]    weekday;
	} cal_state_t;

	// first day number past the end of the month; zero for a month that does not exist
	function automatic logic [LIMIT_W-1:0] month_limit(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [LIMIT_W-1:0] lim;
		begin
			case (month)
				7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 6'd32;
				7'd4, 7'd6, 7'd9, 7'd11: lim = 6'd31;
				7'd2: lim = leap ? 6'd30 : 6'd29;
				default: lim = 6'd0;
			endcase
			return lim;
		end
	endfunction

endpackage
`default_nettype wire

@@ hdl/rtccal_if.sv @@
`default_nettype none
interface rtccal_cmd_if;
	import rtccal_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [HOURS_W-1:0]   new_hours;
	logic [MINUTES_W-1:0] new_minutes;
	logic [SECONDS_W-1:0] new_seconds;
	logic [NDAY_W-1:0]    new_day;
	logic [NMONTH_W-1:0]  new_month;
	logic [NYEAR_W-1:0]   new_year_high;
	logic [NYEAR_W-1:0]   new_year_low;
	logic [NWDAY_W-1:0]   new_weekday;

	modport source(output valid, command, new_hours, new_minutes, new_seconds, new_day,
		new_month, new_year_high, new_year_low, new_weekday, input ready);
	modport sink(input valid, command, new_hours, new_minutes, new_seconds, new_day,
		new_month, new_year_high, new_year_low, new_weekday, output ready);
endinterface

interface rtccal_time_if;
	import rtccal_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [HOURS_W-1:0]   cur_hours;
	logic [MINUTES_W-1:0] cur_minutes;
	logic [SECONDS_W-1:0] cur_seconds;
	logic [DAY_W-1:0]     cur_day;
	logic [MONTH_W-1:0]   cur_month;
	logic [YEAR_W-1:0]    cur_year;
	logic [WDAY_W-1:0]    cur_weekday;

	modport source(output valid, cur_hours, cur_minutes, cur_seconds, cur_day, cur_month,
		cur_year, cur_weekday, input ready);
	modport sink(input valid, cur_hours, cur_minutes, cur_seconds, cur_day, cur_month,
		cur_year, cur_weekday, output ready);
endinterface
`default_nettype wire

@@ hdl/rtc_calendar_counter.sv @@
`default_nettype none
// Calendar counter: one command transaction in, one time/date transaction out.
// Path: input register, then result register holding the updated calendar.
// Throughput: one transaction per cycle while the result side does not stall,
// set by the combinational next-state logic.
// Reset: calendar clears to 00:00:00, weekday 0, day 1, month 1, year 1990;
// both stages empty.
module rtc_calendar_counter (
	input wire clk,
	input wire arst_n,
	rtccal_cmd_if.sink    cmd,
	rtccal_time_if.source cal
);
	import rtccal_pkg::*;

	cmd_item_t  item_s1;
	logic       vld_s1;
	cal_state_t state_q;
	cal_state_t state_nxt;
	logic       out_vld_q;
	logic       out_free;
	logic       adv;

	assign out_free  = !out_vld_q || cal.ready;
	assign adv       = vld_s1 && out_free;
	assign cmd.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.command       <= cmd.command;
			item_s1.new_hours     <= cmd.new_hours;
			item_s1.new_minutes   <= cmd.new_minutes;
			item_s1.new_seconds   <= cmd.new_seconds;
			item_s1.new_day       <= cmd.new_day;
			item_s1.new_month     <= cmd.new_month;
			item_s1.new_year_high <= cmd.new_year_high;
			item_s1.new_year_low  <= cmd.new_year_low;
			item_s1.new_weekday   <= cmd.new_weekday;
		end
	end

	rtccal_next u_next (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hours   <= '0;
			state_q.minutes <= '0;
			state_q.seconds <= '0;
			state_q.weekday <= '0;
			state_q.day     <= 7'd1;
			state_q.month   <= 7'd1;
			state_q.year    <= YEAR_RESET;
			out_vld_q       <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	assign cal.valid       = out_vld_q;
	assign cal.cur_hours   = state_q.hours;
	assign cal.cur_minutes = state_q.minutes;
	assign cal.cur_seconds = state_q.seconds;
	assign cal.cur_day     = state_q.day;
	assign cal.cur_month   = state_q.month;
	assign cal.cur_year    = state_q.year;
	assign cal.cur_weekday = state_q.weekday;
endmodule
`default_nettype wire

@@ hdl/rtccal_next.sv @@
`default_nettype none
module rtccal_next (
	input  wire rtccal_pkg::cal_state_t cur,
	input  wire rtccal_pkg::cmd_item_t  item,
	output rtccal_pkg::cal_state_t      nxt
);
	import rtccal_pkg::*;

	logic [SECONDS_W:0]   sec_t;
	logic [MINUTES_W:0]   min_t;
	logic [HOURS_W:0]     hour_t;
	logic                 sec_c, min_c, hour_c;
	logic [WDAY_W:0]      wday_t;
	logic [DAY_W:0]       day_t;
	logic [MONTH_W:0]     month_t;
	logic [LIMIT_W-1:0]   limit;
	logic [YEAR_W-1:0]    set_year;
	cal_state_t           ticked;

	assign sec_t  = {1'b0, cur.seconds} + 7'd1;
	assign sec_c  = sec_t >= SEC_LIMIT;
	assign min_t  = {1'b0, cur.minutes} + {{MINUTES_W{1'b0}}, sec_c};
	assign min_c  = min_t >= MIN_LIMIT;
	assign hour_t = {1'b0, cur.hours} + {{HOURS_W{1'b0}}, min_c};
	assign hour_c = hour_t >= HOUR_LIMIT;

	assign wday_t  = {1'b0, cur.weekday} + 8'd1;
	assign day_t   = {1'b0, cur.day} + 8'd1;
	assign month_t = {1'b0, cur.month} + 8'd1;
	assign limit   = month_limit(cur.month, cur.year[1:0] == 2'b00);

	assign set_year = YEAR_W'({7'b0, item.new_year_high} * CENTURY)
		+ {7'b0, item.new_year_low};

	always_comb begin
		ticked         = cur;
		ticked.seconds = sec_c ? '0 : sec_t[SECONDS_W-1:0];
		ticked.minutes = min_c ? '0 : min_t[MINUTES_W-1:0];
		ticked.hours   = hour_c ? '0 : hour_t[HOURS_W-1:0];
		if (hour_c) begin
			ticked.weekday = (wday_t >= WDAY_LIMIT) ? '0 : wday_t[WDAY_W-1:0];
			if (limit == '0) begin
				ticked.day     = ERR_MARK;
				ticked.month   = ERR_MARK;
				ticked.weekday = ERR_MARK;
			end else if (day_t >= {2'b0, limit}) begin
				ticked.day = 7'd1;
				if (month_t >= MONTH_END) begin
					ticked.month = 7'd1;
					ticked.year  = (cur.year >= YEAR_MAX) ? '0 : cur.year + 14'd1;
				end else begin
					ticked.month = month_t[MONTH_W-1:0];
				end
			end else begin
				ticked.day = day_t[DAY_W-1:0];
			end
		end
	end

	always_comb begin
		nxt = cur;
		case (item.command)
			CMD_TICK: nxt = ticked;
			CMD_SET_TIME, CMD_SET_ALL: begin
				nxt.hours   = item.new_hours;
				nxt.minutes = item.new_minutes;
				nxt.seconds = item.new_seconds;
				if (item.command == CMD_SET_ALL) begin
					nxt.day     = {2'b0, item.new_day};
					nxt.month   = {3'b0, item.new_month};
					nxt.year    = set_year;
					nxt.weekday = {4'b0, item.new_weekday};
				end
			end
			CMD_READ: nxt = cur;
			default: nxt = cur;
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/rtccal_checker.sv @@
`default_nettype none
module rtccal_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [6:0]  cur_day,
	input wire [6:0]  cur_month,
	input wire [13:0] cur_year,
	input wire [6:0]  cur_weekday,
	input wire [5:0]  cur_seconds
);
	import rtccal_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cur_year) && $stable(cur_day)
			&& $stable(cur_seconds))
		else $error("result payload changed while stalled");

	a_err_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((cur_month == ERR_MARK)
			== (cur_day == ERR_MARK && cur_weekday == ERR_MARK)))
		else $error("error mark not applied to day, month and weekday together");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an accepted command");
endmodule

bind rtc_calendar_counter rtccal_checker u_rtccal_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.out_valid   (cal.valid),
	.out_ready   (cal.ready),
	.cur_day     (cal.cur_day),
	.cur_month   (cal.cur_month),
	.cur_year    (cal.cur_year),
	.cur_weekday (cal.cur_weekday),
	.cur_seconds (cal.cur_seconds)
);
`default_nettype wire

@@ tb/tb_rtc_calendar_counter.sv @@
`default_nettype none
module tb_rtc_calendar_counter;
	import rtccal_pkg::*;

	localparam int SEC_WRAP     = 60;
	localparam int MIN_WRAP     = 60;
	localparam int HOUR_WRAP    = 24;
	localparam int WDAY_WRAP    = 7;
	localparam int MONTH_WRAP   = 13;
	localparam int YEAR_TOP     = 9999;
	localparam int RANDOM_ITEMS = 1550;
	localparam int SEGMENT      = 200;
	localparam int TAIL_CYCLES  = 8;
	localparam int MAX_PRINTS   = 100;
	localparam int TIMEOUT      = 400000;

	typedef struct {
		cmd_item_t   item;
		int unsigned ph;
		bit          drain;
	} backlog_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtccal_cmd_if  cmd_bus();
	rtccal_time_if time_bus();

	rtc_calendar_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.cal(time_bus)
	);

	backlog_entry_t cmd_backlog[$];
	cal_state_t     expected_times[$];
	cal_state_t     shadow_cal;
	cal_state_t     seen_cal;
	cal_state_t     want_cal;
	cmd_item_t      seen_cmd;
	bit             cmd_took = 1'b0;
	int unsigned    idle_pct = 0;
	int unsigned    stall_pct = 0;
	int             errors = 0;

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic cal_state_t next_calendar(input cal_state_t cur, input cmd_item_t c);
		int sec, mins, hrs, wday, dom, mon, yr, lim;
		cal_state_t nxt;
		sec  = int'(cur.seconds);
		mins = int'(cur.minutes);
		hrs  = int'(cur.hours);
		wday = int'(cur.weekday);
		dom  = int'(cur.day);
		mon  = int'(cur.month);
		yr   = int'(cur.year);
		case (c.command)
			CMD_TICK: begin
				sec++;
				if (sec >= SEC_WRAP) begin
					mins++;
					sec = 0;
				end
				if (mins >= MIN_WRAP) begin
					hrs++;
					mins = 0;
				end
				if (hrs >= HOUR_WRAP) begin
					hrs = 0;
					wday++;
					dom++;
					if (wday >= WDAY_WRAP)
						wday = 0;
					case (mon)
						1, 3, 5, 7, 8, 10, 12: lim = 32;
						4, 6, 9, 11: lim = 31;
						2: lim = (yr % 4 == 0) ? 30 : 29;
						default: lim = 0;
					endcase
					if (lim == 0) begin
						dom  = int'(ERR_MARK);
						mon  = int'(ERR_MARK);
						wday = int'(ERR_MARK);
					end else if (dom >= lim) begin
						dom = 1;
						mon++;
						if (mon >= MONTH_WRAP) begin
							mon = 1;
							yr = (yr >= YEAR_TOP) ? 0 : yr + 1;
						end
					end
				end
			end
			CMD_SET_TIME, CMD_SET_ALL: begin
				hrs  = int'(c.new_hours);
				mins = int'(c.new_minutes);
				sec  = int'(c.new_seconds);
				if (c.command == CMD_SET_ALL) begin
					dom  = int'(c.new_day);
					mon  = int'(c.new_month);
					yr   = int'(c.new_year_high) * 100 + int'(c.new_year_low);
					wday = int'(c.new_weekday);
				end
			end
			default: ;
		endcase
		nxt.hours   = hrs[HOURS_W-1:0];
		nxt.minutes = mins[MINUTES_W-1:0];
		nxt.seconds = sec[SECONDS_W-1:0];
		nxt.day     = dom[DAY_W-1:0];
		nxt.month   = mon[MONTH_W-1:0];
		nxt.year    = yr[YEAR_W-1:0];
		nxt.weekday = wday[WDAY_W-1:0];
		return nxt;
	endfunction

	function automatic cmd_item_t with_command(input logic [CMD_W-1:0] op);
		cmd_item_t it;
		it.command       = op;
		it.new_hours     = HOURS_W'($urandom_range(31));
		it.new_minutes   = MINUTES_W'($urandom_range(63));
		it.new_seconds   = SECONDS_W'($urandom_range(63));
		it.new_day       = NDAY_W'($urandom_range(31));
		it.new_month     = NMONTH_W'($urandom_range(15));
		it.new_year_high = NYEAR_W'($urandom_range(127));
		it.new_year_low  = NYEAR_W'($urandom_range(127));
		it.new_weekday   = NWDAY_W'($urandom_range(7));
		return it;
	endfunction

	function automatic cmd_item_t set_time_item(input int h, input int m, input int s);
		cmd_item_t it;
		it = with_command(CMD_SET_TIME);
		it.new_hours   = HOURS_W'(h);
		it.new_minutes = MINUTES_W'(m);
		it.new_seconds = SECONDS_W'(s);
		return it;
	endfunction

	function automatic cmd_item_t set_all_item(input int h, input int m, input int s,
			input int d, input int mo, input int yh, input int yl, input int wd);
		cmd_item_t it;
		it = set_time_item(h, m, s);
		it.command       = CMD_SET_ALL;
		it.new_day       = NDAY_W'(d);
		it.new_month     = NMONTH_W'(mo);
		it.new_year_high = NYEAR_W'(yh);
		it.new_year_low  = NYEAR_W'(yl);
		it.new_weekday   = NWDAY_W'(wd);
		return it;
	endfunction

	task automatic push_cmd(input cmd_item_t it, input int unsigned ph, input bit drain);
		backlog_entry_t e;
		e.item  = it;
		e.ph    = ph;
		e.drain = drain;
		cmd_backlog.push_back(e);
	endtask

	// driver: present the next transaction or idle
	always @(negedge clk) begin
		if (arst_n && (!cmd_bus.valid || cmd_took)) begin
			if (cmd_backlog.size() != 0) begin
				case (cmd_backlog[0].ph)
					1: begin idle_pct = 61; stall_pct = 0; end
					2: begin idle_pct = 0; stall_pct = 61; end
					3: begin idle_pct = 35; stall_pct = 35; end
					default: begin idle_pct = 0; stall_pct = 0; end
				endcase
			end
			if (cmd_backlog.size() != 0
					&& !(cmd_backlog[0].drain && expected_times.size() != 0)
					&& $urandom_range(99) >= idle_pct) begin
				cmd_bus.valid         <= 1'b1;
				cmd_bus.command       <= cmd_backlog[0].item.command;
				cmd_bus.new_hours     <= cmd_backlog[0].item.new_hours;
				cmd_bus.new_minutes   <= cmd_backlog[0].item.new_minutes;
				cmd_bus.new_seconds   <= cmd_backlog[0].item.new_seconds;
				cmd_bus.new_day       <= cmd_backlog[0].item.new_day;
				cmd_bus.new_month     <= cmd_backlog[0].item.new_month;
				cmd_bus.new_year_high <= cmd_backlog[0].item.new_year_high;
				cmd_bus.new_year_low  <= cmd_backlog[0].item.new_year_low;
				cmd_bus.new_weekday   <= cmd_backlog[0].item.new_weekday;
				cmd_backlog.pop_front();
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
		if (arst_n)
			time_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: predict on each command transaction, check each time transaction
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_took <= cmd_bus.valid && cmd_bus.ready;
			if (time_bus.valid && time_bus.ready) begin
				seen_cal = {time_bus.cur_hours, time_bus.cur_minutes, time_bus.cur_seconds,
					time_bus.cur_day, time_bus.cur_month, time_bus.cur_year,
					time_bus.cur_weekday};
				if (expected_times.size() == 0) begin
					report_mismatch("unexpected result, hours", int'(seen_cal.hours), 0);
				end else begin
					want_cal = expected_times.pop_front();
					if (seen_cal.hours !== want_cal.hours)
						report_mismatch("hours", int'(seen_cal.hours), int'(want_cal.hours));
					if (seen_cal.minutes !== want_cal.minutes)
						report_mismatch("minutes", int'(seen_cal.minutes),
							int'(want_cal.minutes));
					if (seen_cal.seconds !== want_cal.seconds)
						report_mismatch("seconds", int'(seen_cal.seconds),
							int'(want_cal.seconds));
					if (seen_cal.day !== want_cal.day)
						report_mismatch("day", int'(seen_cal.day), int'(want_cal.day));
					if (seen_cal.month !== want_cal.month)
						report_mismatch("month", int'(seen_cal.month), int'(want_cal.month));
					if (seen_cal.year !== want_cal.year)
						report_mismatch("year", int'(seen_cal.year), int'(want_cal.year));
					if (seen_cal.weekday !== want_cal.weekday)
						report_mismatch("weekday", int'(seen_cal.weekday),
							int'(want_cal.weekday));
				end
			end
			if (cmd_bus.valid && cmd_bus.ready) begin
				seen_cmd = {cmd_bus.command, cmd_bus.new_hours, cmd_bus.new_minutes,
					cmd_bus.new_seconds, cmd_bus.new_day, cmd_bus.new_month,
					cmd_bus.new_year_high, cmd_bus.new_year_low, cmd_bus.new_weekday};
				shadow_cal = next_calendar(shadow_cal, seen_cmd);
				expected_times.push_back(shadow_cal);
			end
		end
	end

	initial begin
		cmd_item_t   it;
		int unsigned n;
		int unsigned ph;
		int unsigned last_ph;
		int unsigned pick;
		int unsigned burst;
		bit          drain;

		cmd_bus.valid         = 1'b0;
		cmd_bus.command       = CMD_READ;
		cmd_bus.new_hours     = '0;
		cmd_bus.new_minutes   = '0;
		cmd_bus.new_seconds   = '0;
		cmd_bus.new_day       = '0;
		cmd_bus.new_month     = '0;
		cmd_bus.new_year_high = '0;
		cmd_bus.new_year_low  = '0;
		cmd_bus.new_weekday   = '0;
		time_bus.ready        = 1'b0;

		shadow_cal.hours   = '0;
		shadow_cal.minutes = '0;
		shadow_cal.seconds = '0;
		shadow_cal.day     = 7'd1;
		shadow_cal.month   = 7'd1;
		shadow_cal.year    = YEAR_RESET;
		shadow_cal.weekday = '0;

		push_cmd(with_command(CMD_READ), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(set_time_item(23, 59, 59), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		// year wrap out of 9999, weekday wrap
		push_cmd(set_all_item(23, 59, 59, 31, 12, 99, 99, 6), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		// leap February, then into March
		push_cmd(set_all_item(23, 59, 59, 28, 2, 20, 24, 3), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(set_time_item(23, 59, 59), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(set_all_item(23, 59, 59, 28, 2, 20, 23, 5), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		// day past the end of a short month
		push_cmd(set_all_item(23, 59, 59, 31, 4, 19, 99, 2), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		// out of range time with an invalid month
		push_cmd(set_all_item(31, 63, 63, 0, 0, 0, 0, 0), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(set_time_item(23, 59, 59), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		// written year above 9999
		push_cmd(set_all_item(23, 59, 59, 31, 12, 127, 127, 7), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		// minutes over range without a seconds carry
		push_cmd(set_all_item(0, 61, 0, 31, 15, 0, 0, 0), 0, 1'b1);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(set_time_item(23, 59, 58), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(with_command(CMD_TICK), 0, 1'b0);
		push_cmd(with_command(CMD_READ), 0, 1'b0);

		n = 0;
		last_ph = 0;
		while (n < RANDOM_ITEMS) begin
			ph = (n / SEGMENT) % 4;
			drain = (ph != last_ph) || ($urandom_range(99) == 0);
			last_ph = ph;
			pick = $urandom_range(99);
			burst = 0;
			if (pick < 45) begin
				it = with_command(CMD_SET_ALL);
				if ($urandom_range(9) != 0) begin
					it.new_hours   = HOURS_W'(23);
					it.new_minutes = MINUTES_W'(59);
					it.new_seconds = SECONDS_W'($urandom_range(55, 59));
					it.new_month   = ($urandom_range(3) == 0) ? NMONTH_W'(12)
						: NMONTH_W'($urandom_range(1, 12));
					it.new_day     = NDAY_W'($urandom_range(27, 31));
					case ($urandom_range(3))
						0: begin
							it.new_year_high = NYEAR_W'(99);
							it.new_year_low  = NYEAR_W'(99);
						end
						1: begin
							it.new_year_high = NYEAR_W'($urandom_range(19, 20));
							it.new_year_low  = NYEAR_W'($urandom_range(99));
						end
						2: it.new_year_low = NYEAR_W'(4 * $urandom_range(24));
						default: ;
					endcase
				end
				burst = $urandom_range(2, 8);
			end else if (pick < 70) begin
				it = set_time_item($urandom_range(20, 31), $urandom_range(56, 63),
					$urandom_range(56, 63));
				burst = $urandom_range(1, 8);
			end else if (pick < 85) begin
				it = with_command(CMD_TICK);
				burst = $urandom_range(5);
			end else begin
				it = with_command(CMD_W'($urandom_range(3)));
			end
			push_cmd(it, ph, drain);
			n++;
			repeat (burst) begin
				push_cmd(with_command(($urandom_range(5) == 0) ? CMD_READ : CMD_TICK), ph, 1'b0);
				n++;
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || cmd_bus.valid)
			@(negedge clk);
		while (expected_times.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

@@ rtc_calendar_counter.f @@
hdl/rtccal_pkg.sv
hdl/rtccal_if.sv
hdl/rtccal_next.sv
hdl/rtc_calendar_counter.sv
hdl/rtccal_checker.sv
tb/tb_rtc_calendar_counter.sv
